>>> rtl/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg
// Shared types and constants for the fan curve interpolator.
// ----------------------------------------------------------------------------
package fci_pkg;

	localparam int NUM_POINTS = 7;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(NUM_POINTS);
	localparam int PTR_W      = 4;
	localparam int TEMP_W     = 7;
	localparam int SPEED_W    = 12;
	localparam int DIFF_W     = 7;
	localparam int PROD_W     = SPEED_W + DIFF_W;
	localparam int DCNT_W     = $clog2(PROD_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Power-up quiet profile; points past the seventh sit at the top.
	localparam logic [TEMP_W-1:0] DFLT_TEMP [MAX_POINTS] = '{
		7'd0, 7'd25, 7'd45, 7'd65, 7'd80, 7'd90, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
	};
	localparam logic [SPEED_W-1:0] DFLT_SPEED [MAX_POINTS] = '{
		12'd120, 12'd420, 12'd840, 12'd1050, 12'd1680, 12'd2100, 12'd2100, 12'd2100,
		12'd2100, 12'd2100, 12'd2100, 12'd2100, 12'd2100, 12'd2100, 12'd2100, 12'd2100
	};

	localparam logic [SPEED_W-1:0] RST_SPEED_CEIL  = 12'd2100;
	localparam logic [SPEED_W-1:0] RST_FIRST_FLOOR = 12'd120;
	localparam logic [SPEED_W-1:0] RST_OTHER_FLOOR = 12'd840;
	localparam logic [TEMP_W-1:0]  RST_TEMP_FLOOR  = 7'd0;
	localparam logic [TEMP_W-1:0]  RST_TEMP_CEIL   = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_CEIL  = 3'd0,
		CFG_FIRST_FLOOR = 3'd1,
		CFG_OTHER_FLOOR = 3'd2,
		CFG_TEMP_FLOOR  = 3'd3,
		CFG_TEMP_CEIL   = 3'd4
	} fci_cfg_idx_t;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_UPDATE = 1'b1
	} fci_action_t;

	typedef enum logic {
		STS_DONE    = 1'b0,
		STS_BAD_IDX = 1'b1
	} fci_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_UPREV,
		ST_UNEXT,
		ST_FIN
	} fci_state_t;

	typedef struct packed {
		logic                action;
		logic [PTR_W-1:0]    point_index;
		logic signed [7:0]   temperature;
		logic [SPEED_W-1:0]  speed_in;
	} fci_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed_out;
		logic [TEMP_W-1:0]   point_temp;
		logic [SPEED_W-1:0]  point_speed;
		logic                status;
	} fci_out_t;

endpackage

>>> rtl/fan_curve_interpolator_unit.sv
// ----------------------------------------------------------------------------
// fan_curve_interpolator_unit
// Piecewise-linear fan curve: lookup of speed by temperature, and clamped
// edits of single breakpoints.
//
//   channel  handshake            payload
//   in       in_valid / in_stall   in_data  (fci_in_t)
//   out      out_valid / out_stall out_data (fci_out_t)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request at a time; in_stall is high from acceptance until the result
// is handed to the output register. A lookup reads one breakpoint per cycle,
// uses the shared multiplier in ST_MUL1 and ST_MUL2, then runs the serial
// divider at one quotient bit per cycle. An update passes ST_UPREV and
// ST_UNEXT; a rejected update goes straight to ST_FIN. Reset brings back the
// default profile at once through per-point valid bits. The output register
// holds a result under out_stall while the next request is taken.
// ----------------------------------------------------------------------------
module fan_curve_interpolator_unit
	import fci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fci_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fci_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_POINTS - 1);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(PROD_W - 1);

	fci_state_t state_q, state_d;

	// configuration
	logic [SPEED_W-1:0] speed_ceil_q, first_floor_q, other_floor_q;
	logic [TEMP_W-1:0]  temp_floor_q, temp_ceil_q;

	// breakpoint store
	logic [TEMP_W-1:0]     temp_mem  [NUM_POINTS];
	logic [SPEED_W-1:0]    speed_mem [NUM_POINTS];
	logic [NUM_POINTS-1:0] pt_valid_q;
	logic [TEMP_W-1:0]     rd_temp_q;
	logic [SPEED_W-1:0]    rd_speed_q;
	logic                  rd_vld_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [IDX_W-1:0]      rd_addr;
	logic [TEMP_W-1:0]     rd_t;
	logic [SPEED_W-1:0]    rd_s;
	logic                  mem_we;

	// request and working registers
	fci_in_t               req_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TEMP_W-1:0]     prev_t_q, first_t_q;
	logic [SPEED_W-1:0]    prev_s_q, first_s_q, s2_q;
	logic [DIFF_W-1:0]     w_q, d_q;
	logic [PROD_W-1:0]     num_q;
	logic [DIFF_W-1:0]     rem_q;
	logic [DCNT_W-1:0]     div_cnt_q;
	logic signed [8:0]     t_work_q;
	fci_out_t              res_q;

	logic signed [8:0]     t_sx, prev_sx, cur_sx, lo_sx, hi_sx, t_clamp;
	logic                  scan_hit;
	logic [8:0]            d_full;
	logic [SPEED_W-1:0]    mul_a;
	logic [DIFF_W-1:0]     mul_b;
	logic [PROD_W-1:0]     prod;
	logic [DIFF_W:0]       trial_rem;
	logic [DIFF_W+1:0]     trial_diff;
	logic                  q_bit;
	logic [SPEED_W-1:0]    s_clamp, s_floor;
	logic                  fin_xfer;
	logic                  in_accept;
	logic                  idx_bad;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign idx_bad   = (32'(in_data.point_index) >= NUM_POINTS);
	assign fin_xfer  = (state_q == ST_FIN) && (!out_valid || !out_stall);

	// unwritten points read as the power-up profile
	assign rd_t = rd_vld_q ? rd_temp_q  : DFLT_TEMP[PTR_W'(rd_idx_q)];
	assign rd_s = rd_vld_q ? rd_speed_q : DFLT_SPEED[PTR_W'(rd_idx_q)];

	assign t_sx    = 9'(req_q.temperature);
	assign prev_sx = $signed({2'b00, prev_t_q});
	assign cur_sx  = $signed({2'b00, rd_t});
	assign lo_sx   = cur_sx + 9'sd1;
	assign hi_sx   = cur_sx - 9'sd1;
	assign scan_hit = (rd_idx_q != '0) && (t_sx >= prev_sx) && (t_sx <= cur_sx);
	assign d_full  = 9'(t_sx - prev_sx);

	// shared multiplier
	assign mul_a = (state_q == ST_MUL1) ? prev_s_q : s2_q;
	assign mul_b = (state_q == ST_MUL1) ? DIFF_W'(w_q - d_q) : d_q;
	assign prod  = PROD_W'(mul_a * mul_b);

	// restoring divider step
	assign trial_rem  = {rem_q, num_q[PROD_W-1]};
	assign trial_diff = {1'b0, trial_rem} - {2'b00, w_q};
	assign q_bit      = !trial_diff[DIFF_W+1];

	// update clamps
	always_comb begin
		t_clamp = t_work_q;
		if (idx_q != LAST_IDX && t_clamp > hi_sx) t_clamp = hi_sx;
		if (t_clamp > $signed({2'b00, temp_ceil_q})) t_clamp = $signed({2'b00, temp_ceil_q});
		if (t_clamp < $signed({2'b00, temp_floor_q})) t_clamp = $signed({2'b00, temp_floor_q});
		s_floor = (idx_q == '0) ? first_floor_q : other_floor_q;
		s_clamp = req_q.speed_in;
		if (s_clamp > speed_ceil_q) s_clamp = speed_ceil_q;
		if (s_clamp < s_floor) s_clamp = s_floor;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		rd_addr = rd_idx_q;
		mem_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
				if (in_data.action == ACT_UPDATE && in_data.point_index != '0)
					rd_addr = IDX_W'(in_data.point_index - 1'b1);
				if (in_accept) begin
					if (in_data.action == ACT_LOOKUP) state_d = ST_SCAN;
					else if (idx_bad) state_d = ST_FIN;
					else state_d = ST_UPREV;
				end
			end
			ST_SCAN: begin
				rd_addr = (rd_idx_q == LAST_IDX) ? rd_idx_q : rd_idx_q + 1'b1;
				if (scan_hit) state_d = (rd_t == prev_t_q) ? ST_FIN : ST_MUL1;
				else if (rd_idx_q == LAST_IDX) state_d = ST_FIN;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == '0) state_d = ST_FIN;
			end
			ST_UPREV: begin
				rd_addr = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
				state_d = ST_UNEXT;
			end
			ST_UNEXT: begin
				mem_we  = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_xfer) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_idx_q <= rd_addr;
			rd_vld_q <= pt_valid_q[rd_addr];
		end
	end

	// breakpoint memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			temp_mem[idx_q]  <= t_clamp[TEMP_W-1:0];
			speed_mem[idx_q] <= s_clamp;
		end
		rd_temp_q  <= temp_mem[rd_addr];
		rd_speed_q <= speed_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q <= '0;
		end else if (mem_we) begin
			pt_valid_q[idx_q] <= 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_ceil_q  <= RST_SPEED_CEIL;
			first_floor_q <= RST_FIRST_FLOOR;
			other_floor_q <= RST_OTHER_FLOOR;
			temp_floor_q  <= RST_TEMP_FLOOR;
			temp_ceil_q   <= RST_TEMP_CEIL;
		end else if (cfg_valid && cfg_ready) begin
			case (fci_cfg_idx_t'(cfg_index))
				CFG_SPEED_CEIL:  speed_ceil_q  <= cfg_data[SPEED_W-1:0];
				CFG_FIRST_FLOOR: first_floor_q <= cfg_data[SPEED_W-1:0];
				CFG_OTHER_FLOOR: other_floor_q <= cfg_data[SPEED_W-1:0];
				CFG_TEMP_FLOOR:  temp_floor_q  <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_CEIL:   temp_ceil_q   <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				idx_q <= in_data.point_index[IDX_W-1:0];
				res_q.speed_out   <= '0;
				res_q.point_temp  <= '0;
				res_q.point_speed <= '0;
				res_q.status      <= (in_data.action == ACT_UPDATE && idx_bad) ?
					STS_BAD_IDX : STS_DONE;
			end
			ST_SCAN: begin
				if (rd_idx_q == '0) begin
					first_t_q <= rd_t;
					first_s_q <= rd_s;
				end
				if (scan_hit) begin
					s2_q     <= rd_s;
					w_q      <= DIFF_W'(rd_t - prev_t_q);
					d_q      <= d_full[DIFF_W-1:0];
					res_q.speed_out <= prev_s_q;
				end else begin
					prev_t_q <= rd_t;
					prev_s_q <= rd_s;
					if (rd_idx_q == LAST_IDX) begin
						// nothing brackets: clamp to an end of the curve
						res_q.speed_out <= (t_sx <= $signed({2'b00, first_t_q})) ?
							first_s_q : rd_s;
					end
				end
			end
			ST_MUL1: num_q <= prod;
			ST_MUL2: begin
				num_q     <= num_q + prod;
				rem_q     <= '0;
				div_cnt_q <= DIV_LAST;
			end
			ST_DIV: begin
				rem_q     <= q_bit ? trial_diff[DIFF_W-1:0] : trial_rem[DIFF_W-1:0];
				num_q     <= {num_q[PROD_W-2:0], q_bit};
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0)
					res_q.speed_out <= {num_q[SPEED_W-2:0], q_bit};
			end
			ST_UPREV: begin
				t_work_q <= (idx_q != '0 && t_sx < lo_sx) ? lo_sx : t_sx;
			end
			ST_UNEXT: begin
				res_q.point_temp  <= t_clamp[TEMP_W-1:0];
				res_q.point_speed <= s_clamp;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_xfer) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_xfer) out_data <= res_q;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("request accepted but unit not busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_DIV) |-> (w_q != '0))
		else $error("interpolation on zero-width segment");

	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '0) |=> (num_q[PROD_W-1:SPEED_W] == '0))
		else $error("interpolated speed overflows");

	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_xfer |=> (out_valid && state_q == ST_IDLE))
		else $error("result not moved to output register");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(idx_q) < NUM_POINTS && req_q.action == ACT_UPDATE))
		else $error("breakpoint write out of range");

endmodule

>>> tb/tb_fan_curve_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fan_curve_interpolator_unit
// Self-checking bench for the fan curve block. A short table of directed
// lookups, edits and register writes comes first. Random phases follow, each
// with its own clamp limits. Responses are compared with an in-bench model
// of the breakpoint table, or with a fixed response on some directed rows.
// The input idles and the output stalls at random.
module tb_fan_curve_interpolator_unit;
	import fci_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 64;

	typedef enum logic [1:0] {
		ROW_LOOKUP,
		ROW_UPDATE,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		fci_in_t      req;
		bit           typed;
		fci_out_t     rsp;
		fci_cfg_idx_t reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	fci_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	fci_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model of the breakpoint table and its clamp limits
	logic [TEMP_W-1:0]  curve_temps [NUM_POINTS];
	logic [SPEED_W-1:0] curve_speeds [NUM_POINTS];
	logic [SPEED_W-1:0] lim_speed_ceil  = RST_SPEED_CEIL;
	logic [SPEED_W-1:0] lim_first_floor = RST_FIRST_FLOOR;
	logic [SPEED_W-1:0] lim_other_floor = RST_OTHER_FLOOR;
	logic [TEMP_W-1:0]  lim_temp_floor  = RST_TEMP_FLOOR;
	logic [TEMP_W-1:0]  lim_temp_ceil   = RST_TEMP_CEIL;

	fci_out_t expected_responses [$];
	dir_row_t dir_rows [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	bit       tx_quiet = 1'b0;
	bit       rx_quiet = 1'b0;
	bit       hold_pending = 1'b0;

	fan_curve_interpolator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Response for one request; an accepted edit also updates the table.
	function automatic fci_out_t predict_curve_response(fci_in_t req);
		fci_out_t rsp;
		int t, t1, t2, s1, s2, w, d, lo, hi, pidx, s, s_floor;
		bit found;
		rsp = '0;
		t = $signed(req.temperature);
		if (req.action == ACT_LOOKUP) begin
			found = 1'b0;
			for (int i = 0; i + 1 < NUM_POINTS && !found; i++) begin
				t1 = int'(curve_temps[i]);
				t2 = int'(curve_temps[i+1]);
				if (t >= t1 && t <= t2) begin
					found = 1'b1;
					s1 = int'(curve_speeds[i]);
					s2 = int'(curve_speeds[i+1]);
					if (t1 == t2) begin
						rsp.speed_out = curve_speeds[i];
					end else begin
						w = t2 - t1;
						d = t - t1;
						rsp.speed_out = SPEED_W'((s1 * (w - d) + s2 * d) / w);
					end
				end
			end
			// nothing brackets it: clamp to an end of the table
			if (!found) begin
				if (t <= int'(curve_temps[0]))
					rsp.speed_out = curve_speeds[0];
				else
					rsp.speed_out = curve_speeds[NUM_POINTS-1];
			end
		end else if (int'(req.point_index) >= NUM_POINTS) begin
			rsp.status = STS_BAD_IDX;
		end else begin
			pidx = int'(req.point_index);
			s_floor = (pidx == 0) ? int'(lim_first_floor) : int'(lim_other_floor);
			if (pidx > 0) begin
				lo = int'(curve_temps[pidx-1]) + 1;
				if (t < lo)
					t = lo;
			end
			// neighbor above takes priority over neighbor below
			if (pidx + 1 < NUM_POINTS) begin
				hi = int'(curve_temps[pidx+1]) - 1;
				if (t > hi)
					t = hi;
			end
			if (t > int'(lim_temp_ceil))
				t = int'(lim_temp_ceil);
			if (t < int'(lim_temp_floor))
				t = int'(lim_temp_floor);
			s = int'(req.speed_in);
			if (s > int'(lim_speed_ceil))
				s = int'(lim_speed_ceil);
			if (s < s_floor)
				s = s_floor;
			curve_temps[pidx] = TEMP_W'(t);
			curve_speeds[pidx] = SPEED_W'(s);
			rsp.point_temp = TEMP_W'(t);
			rsp.point_speed = SPEED_W'(s);
			rsp.status = STS_DONE;
		end
		return rsp;
	endfunction

	function automatic fci_in_t make_req(fci_action_t act, int idx, int temp, int spd);
		fci_in_t req;
		req.action = act;
		req.point_index = PTR_W'(idx);
		req.temperature = 8'(temp);
		req.speed_in = SPEED_W'(spd);
		return req;
	endfunction

	function automatic void add_row(row_kind_t kind, fci_in_t req, bit typed, fci_out_t rsp);
		dir_row_t row;
		row.kind = kind;
		row.req = req;
		row.typed = typed;
		row.rsp = rsp;
		row.reg_idx = CFG_SPEED_CEIL;
		row.reg_val = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg_row(fci_cfg_idx_t idx, int val);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.req = '0;
		row.typed = 1'b0;
		row.rsp = '0;
		row.reg_idx = idx;
		row.reg_val = CFG_DATA_W'(val);
		dir_rows.push_back(row);
	endfunction

	function automatic fci_out_t lookup_rsp(int spd);
		fci_out_t rsp;
		rsp = '0;
		rsp.speed_out = SPEED_W'(spd);
		rsp.status = STS_DONE;
		return rsp;
	endfunction

	function automatic fci_out_t update_rsp(int temp, int spd, fci_status_t sts);
		fci_out_t rsp;
		rsp = '0;
		rsp.point_temp = TEMP_W'(temp);
		rsp.point_speed = SPEED_W'(spd);
		rsp.status = sts;
		return rsp;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_register(fci_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SPEED_CEIL:  lim_speed_ceil = val;
			CFG_FIRST_FLOOR: lim_first_floor = val;
			CFG_OTHER_FLOOR: lim_other_floor = val;
			CFG_TEMP_FLOOR:  lim_temp_floor = val[TEMP_W-1:0];
			CFG_TEMP_CEIL:   lim_temp_ceil = val[TEMP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// take the last request off the bus, then wait for every response
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One request: optional gap, then hold it until accepted.
	task automatic issue_request(fci_in_t req, bit typed, fci_out_t typed_rsp);
		fci_out_t rsp;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		rsp = predict_curve_response(req);
		expected_responses.push_back(typed ? typed_rsp : rsp);
	endtask

	// response checker
	initial begin : rsp_check
		fci_out_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					$display("%0t unexpected response: actual speed %0d temp %0d pspeed %0d status %0d",
						$time, out_data.speed_out, out_data.point_temp,
						out_data.point_speed, out_data.status);
					fail_count++;
				end else begin
					want = expected_responses.pop_front();
					if (out_data.speed_out !== want.speed_out) begin
						$display("%0t speed_out mismatch: expected %0d, actual %0d",
							$time, want.speed_out, out_data.speed_out);
						fail_count++;
					end
					if (out_data.point_temp !== want.point_temp) begin
						$display("%0t point_temp mismatch: expected %0d, actual %0d",
							$time, want.point_temp, out_data.point_temp);
						fail_count++;
					end
					if (out_data.point_speed !== want.point_speed) begin
						$display("%0t point_speed mismatch: expected %0d, actual %0d",
							$time, want.point_speed, out_data.point_speed);
						fail_count++;
					end
					if (out_data.status !== want.status) begin
						$display("%0t status mismatch: expected %0d, actual %0d",
							$time, want.status, out_data.status);
						fail_count++;
					end
				end
			end
		end
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int stall_left;
		int hold_left;
		int r;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_stall <= 1'b0;
				end else if (r < 95) begin
					stall_left = $urandom_range(0, 2);
					out_stall <= 1'b1;
				end else begin
					stall_left = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		fci_in_t req;
		int r;
		for (int i = 0; i < NUM_POINTS; i++) begin
			curve_temps[i] = DFLT_TEMP[i];
			curve_speeds[i] = DFLT_SPEED[i];
		end

		// directed table; typed responses only where obvious from the reset profile
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, -128, 0), 1'b1, lookup_rsp(120));
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 15, 127, 4095), 1'b1, lookup_rsp(2100));
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 0, 0), 1'b1, lookup_rsp(120));
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 3, 25, 7), 1'b1, lookup_rsp(420));
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 37, 0), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 9, 83, 2048), 1'b0, '0);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 7, 50, 1000), 1'b1,
			update_rsp(0, 0, STS_BAD_IDX));
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 15, -1, 4095), 1'b1,
			update_rsp(0, 0, STS_BAD_IDX));
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 0, -128, 0), 1'b1,
			update_rsp(0, 120, STS_DONE));
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 6, 127, 4095), 1'b1,
			update_rsp(100, 2100, STS_DONE));
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 3, 50, 900), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 47, 0), 1'b0, '0);
		// low ceiling pulls points out of order and into a zero-width segment
		add_cfg_row(CFG_TEMP_CEIL, 20);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 4, 90, 1500), 1'b0, '0);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 5, 90, 1600), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 60, 0), 1'b0, '0);
		// temperature floor above the ceiling wins
		add_cfg_row(CFG_TEMP_FLOOR, 110);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 0, 0, 4095), 1'b0, '0);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 1, 0, 0), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 110, 0), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, -5, 0), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 120, 0), 1'b0, '0);
		// speed floors above the ceiling win
		add_cfg_row(CFG_SPEED_CEIL, 100);
		add_cfg_row(CFG_OTHER_FLOOR, 3000);
		add_cfg_row(CFG_FIRST_FLOOR, 4095);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 2, -128, 4095), 1'b0, '0);
		add_row(ROW_UPDATE, make_req(ACT_UPDATE, 0, 127, 0), 1'b0, '0);
		add_row(ROW_LOOKUP, make_req(ACT_LOOKUP, 0, 111, 0), 1'b0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			tx_quiet = (p == 1 || p == 3 || p == 4);
			rx_quiet = (p == 2 || p == 4);
			case (p)
				0: begin
					write_register(CFG_SPEED_CEIL, RST_SPEED_CEIL);
					write_register(CFG_FIRST_FLOOR, RST_FIRST_FLOOR);
					write_register(CFG_OTHER_FLOOR, RST_OTHER_FLOOR);
					write_register(CFG_TEMP_FLOOR, CFG_DATA_W'(RST_TEMP_FLOOR));
					write_register(CFG_TEMP_CEIL, CFG_DATA_W'(RST_TEMP_CEIL));
				end
				1: begin
					write_register(CFG_SPEED_CEIL, '0);
					write_register(CFG_FIRST_FLOOR, '0);
					write_register(CFG_OTHER_FLOOR, '0);
					write_register(CFG_TEMP_FLOOR, '0);
					write_register(CFG_TEMP_CEIL, '0);
				end
				2: begin
					write_register(CFG_SPEED_CEIL, 12'd4095);
					write_register(CFG_FIRST_FLOOR, 12'd4095);
					write_register(CFG_OTHER_FLOOR, 12'd4095);
					write_register(CFG_TEMP_FLOOR, 12'd127);
					write_register(CFG_TEMP_CEIL, 12'd127);
				end
				3: begin
					write_register(CFG_SPEED_CEIL, 12'd4095);
					write_register(CFG_FIRST_FLOOR, '0);
					write_register(CFG_OTHER_FLOOR, '0);
					write_register(CFG_TEMP_FLOOR, '0);
					write_register(CFG_TEMP_CEIL, 12'd127);
				end
				7: begin
					write_register(CFG_SPEED_CEIL, CFG_DATA_W'($urandom));
					write_register(CFG_FIRST_FLOOR, CFG_DATA_W'($urandom));
					write_register(CFG_OTHER_FLOOR, CFG_DATA_W'($urandom));
					write_register(CFG_TEMP_FLOOR, CFG_DATA_W'($urandom_range(0, 127)));
					write_register(CFG_TEMP_CEIL, CFG_DATA_W'($urandom_range(0, 127)));
				end
				default: begin
					write_register(CFG_SPEED_CEIL, CFG_DATA_W'($urandom_range(1500, 4095)));
					write_register(CFG_FIRST_FLOOR, CFG_DATA_W'($urandom_range(0, 1000)));
					write_register(CFG_OTHER_FLOOR, CFG_DATA_W'($urandom_range(0, 2000)));
					write_register(CFG_TEMP_FLOOR, CFG_DATA_W'($urandom_range(0, 30)));
					write_register(CFG_TEMP_CEIL, CFG_DATA_W'($urandom_range(70, 127)));
				end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long output hold-off while requests keep coming back to back
				if (p == 3 && n == 8)
					hold_pending = 1'b1;
				r = $urandom_range(0, 99);
				req.speed_in = SPEED_W'($urandom);
				req.point_index = PTR_W'($urandom);
				if (r < 65) begin
					req.action = ACT_LOOKUP;
					if ($urandom_range(0, 9) == 0)
						req.temperature = 8'($urandom);
					else
						req.temperature = 8'($urandom_range(0, 140) - 10);
				end else begin
					req.action = ACT_UPDATE;
					if ($urandom_range(0, 9) != 0)
						req.point_index = PTR_W'($urandom_range(0, NUM_POINTS - 1));
					else
						req.point_index = PTR_W'($urandom_range(NUM_POINTS, 15));
					if ($urandom_range(0, 4) != 0)
						req.temperature = 8'($urandom_range(0, 127));
					else
						req.temperature = 8'($urandom);
				end
				issue_request(req, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/fci_pkg.sv
rtl/fan_curve_interpolator_unit.sv
tb/tb_fan_curve_interpolator_unit.sv
